[rtl/tsd_pkg.sv]
// shared widths and constants for the toroidal diffusion stencil
package tsd_pkg;

  localparam int VAL_W     = 32;  // unsigned q16.16 cell value
  localparam int GAIN_W    = 17;  // q1.16 decay gain, below 2.0
  localparam int SUM_W     = 36;  // weighted 3x3 sum, total weight 12
  localparam int PROD_W    = VAL_W + GAIN_W;
  localparam int FRAC_W    = 16;

  // sum / 12 is (sum >> 2) / 3, the latter as a multiply by ceil(2^35 / 3) = 34'h2_AAAA_AAAB
  localparam int QIN_W     = SUM_W - 2;
  localparam int RCP_W     = 17;
  localparam int RCP_SHIFT = 35;
  localparam int LO_PROD_W = QIN_W + RCP_W;
  localparam int HI_SUM_W  = QIN_W + RCP_W + 1;
  localparam logic [RCP_W-1:0] RCP_HI = 17'h15555;
  localparam logic [RCP_W-1:0] RCP_LO = 17'h0AAAB;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [GAIN_W-1:0] gain_t;

endpackage

[rtl/tsd_scale.sv]
// divide the weighted sum by twelve and apply the decay gain, one sum at a time
module tsd_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tsd_pkg::sum_t   sum_in,
  input  tsd_pkg::gain_t  gain,
  input  logic            res_take,
  output logic            res_valid,
  output tsd_pkg::val_t   res_value
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RCP  = 2'd1;
  localparam logic [1:0] PH_MUL  = 2'd2;
  localparam logic [1:0] PH_RES  = 2'd3;

  logic [1:0]                        phase_r, phase_nxt;
  logic [tsd_pkg::QIN_W-1:0]         n_r;
  logic [tsd_pkg::LO_PROD_W-1:0]     lo_r;
  logic [tsd_pkg::HI_SUM_W-1:0]      hi_sum;
  tsd_pkg::val_t                     q_r;
  logic [tsd_pkg::PROD_W-1:0]        prod_r;

  // upper half of the reciprocal product plus the carried top of the lower half
  assign hi_sum = tsd_pkg::HI_SUM_W'(n_r) * tsd_pkg::HI_SUM_W'(tsd_pkg::RCP_HI)
                + tsd_pkg::HI_SUM_W'(lo_r >> tsd_pkg::RCP_W);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_RCP;
        end
      end
      PH_RCP: phase_nxt = PH_MUL;
      PH_MUL: phase_nxt = PH_RES;
      PH_RES: begin
        if (res_take) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && start) begin
      n_r  <= sum_in[tsd_pkg::SUM_W-1:2];
      lo_r <= tsd_pkg::LO_PROD_W'(sum_in[tsd_pkg::SUM_W-1:2])
            * tsd_pkg::LO_PROD_W'(tsd_pkg::RCP_LO);
    end
    if (phase_r == PH_RCP) begin
      // quotient is below 2^32
      q_r <= hi_sum[(tsd_pkg::RCP_SHIFT - tsd_pkg::RCP_W) +: tsd_pkg::VAL_W];
    end
    if (phase_r == PH_MUL) begin
      prod_r <= tsd_pkg::PROD_W'(q_r) * tsd_pkg::PROD_W'(gain);
    end
  end

  assign res_valid = (phase_r == PH_RES);
  // a gain above one may overflow the word, then saturate
  assign res_value = prod_r[tsd_pkg::PROD_W-1] ? '1
                   : prod_r[tsd_pkg::FRAC_W +: tsd_pkg::VAL_W];

  a_take_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> res_valid)
    else $error("result taken while none ready");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> phase_r == PH_IDLE)
    else $error("scale started while busy");

  a_div_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RCP) |=> phase_r == PH_MUL)
    else $error("division did not hand over to the multiply");

endmodule

[rtl/toroidal_stencil_diffuse.sv]
// top level: grid memory, stencil read sequencer and result register
// A write transaction stores one cell. A query transaction reads the nine cells of the 3x3
// neighbourhood from the single-port grid memory, one read per cycle, then divides the weighted
// sum by twelve with a reciprocal multiply in two steps and applies the decay gain in one more
// multiply; the input is held off from the acceptance of a query through the nine reads, the
// addition of the last cell, the two reciprocal steps, the gain multiply and the move into the
// output register, longer while the output register is full and stalled.
// Neighbours wrap round both edges of the grid. A finished result sits in the output register
// and does not block the next transaction. The grid has no reset: a cell must be written
// before any query touches it. decay_gain may only be written while no query is in flight.
module toroidal_stencil_diffuse #(
  parameter int LOG2_WIDTH  = 8,
  parameter int LOG2_HEIGHT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_column,
  input  logic [7:0]  in_row,
  input  logic [31:0] in_cell_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_diffused_value,
  output logic [7:0]  out_column,
  output logic [7:0]  out_row,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  localparam int XW     = LOG2_WIDTH;
  localparam int YW     = LOG2_HEIGHT;
  localparam int ADDR_W = XW + YW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CXW    = (XW > 8) ? XW : 8;
  localparam int CYW    = (YW > 8) ? YW : 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  localparam logic [1:0] OFS_LO  = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_HI  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            dx_r, dy_r;
  logic [XW-1:0]         x_r, in_x;
  logic [YW-1:0]         y_r, in_y;
  logic [CXW-1:0]        col_ext;
  logic [CYW-1:0]        row_ext;
  tsd_pkg::gain_t        gain_r;
  tsd_pkg::val_t         grid_mem [DEPTH];
  tsd_pkg::val_t         rd_q_r;
  logic                  rd_en, wr_en, in_acc;
  logic [ADDR_W-1:0]     rd_addr;
  logic [XW-1:0]         rd_x;
  logic [YW-1:0]         rd_y;
  logic                  rd_vld_r, rd_centre_r, rd_last_r;
  logic                  tap_last;
  tsd_pkg::sum_t         acc_r;
  logic                  start_r;
  logic                  res_valid, res_take;
  tsd_pkg::val_t         res_value;
  logic                  out_valid_r;
  tsd_pkg::val_t         out_val_r;
  logic [7:0]            out_col_r, out_row_r;

  assign col_ext = CXW'(in_column);
  assign row_ext = CYW'(in_row);
  assign in_x    = col_ext[XW-1:0];
  assign in_y    = row_ext[YW-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_command == tsd_pkg::CMD_WRITE);

  // neighbour coordinates wrap through the natural width of the counters
  always_comb begin
    unique case (dx_r)
      OFS_LO:  rd_x = x_r - 1'b1;
      OFS_HI:  rd_x = x_r + 1'b1;
      default: rd_x = x_r;
    endcase
    unique case (dy_r)
      OFS_LO:  rd_y = y_r - 1'b1;
      OFS_HI:  rd_y = y_r + 1'b1;
      default: rd_y = y_r;
    endcase
  end

  assign rd_en    = (state_r == S_READ);
  assign rd_addr  = {rd_y, rd_x};
  assign tap_last = (dx_r == OFS_HI) && (dy_r == OFS_HI);
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_command == tsd_pkg::CMD_QUERY) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (tap_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dx_r        <= OFS_LO;
      dy_r        <= OFS_LO;
      rd_vld_r    <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= tsd_pkg::GAIN_ONE;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      start_r  <= rd_vld_r && rd_last_r;
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (state_r == S_IDLE) begin
        dx_r <= OFS_LO;
        dy_r <= OFS_LO;
      end else if (rd_en) begin
        if (dx_r == OFS_HI) begin
          dx_r <= OFS_LO;
          dy_r <= dy_r + 1'b1;
        end else begin
          dx_r <= dx_r + 1'b1;
        end
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_x;
      y_r <= in_y;
    end
    rd_centre_r <= (dx_r == OFS_MID) && (dy_r == OFS_MID);
    rd_last_r   <= tap_last;
    if (in_acc) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      // centre cell carries weight four
      acc_r <= acc_r + (rd_centre_r ? {2'b00, rd_q_r, 2'b00}
                                    : tsd_pkg::SUM_W'(rd_q_r));
    end
    if (res_take) begin
      out_val_r <= res_value;
      out_col_r <= 8'(x_r);
      out_row_r <= 8'(y_r);
    end
  end

  // grid memory, one port: writes only when idle, reads only while sequencing
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[{in_y, in_x}] <= in_cell_value;
    end
    if (rd_en) begin
      rd_q_r <= grid_mem[rd_addr];
    end
  end

  tsd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .sum_in    (acc_r),
    .gain      (gain_r),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  assign out_valid          = out_valid_r;
  assign out_diffused_value = out_val_r;
  assign out_column         = out_col_r;
  assign out_row            = out_row_r;

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("grid read and write in the same cycle");

  a_data_only_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_READ || state_r == S_SUM))
    else $error("read data returned outside a query");

  a_start_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == S_SUM && !rd_vld_r))
    else $error("scaling started before all nine reads summed");

  a_take_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (state_r == S_IDLE && out_valid_r))
    else $error("result taken but not presented");

endmodule

[tb/testbench.sv]
// testbench for the toroidal 3x3 diffusion stencil: directed and random traffic with scoreboard
`timescale 1ns / 1ps

module testbench;

  localparam int LOG2_WIDTH     = 8;
  localparam int LOG2_HEIGHT    = 8;
  localparam int XMASK          = (1 << LOG2_WIDTH) - 1;
  localparam int YMASK          = (1 << LOG2_HEIGHT) - 1;
  localparam int GRID_CELLS     = 1 << (LOG2_WIDTH + LOG2_HEIGHT);
  localparam int STENCIL_WEIGHT = 12;
  localparam int ITEM_TARGET    = 550;
  localparam int CALM_ITEMS     = 100;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct {
    tsd_pkg::val_t value;
    logic [7:0]    column;
    logic [7:0]    row;
  } diffused_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_column;
  logic [7:0]  in_row;
  logic [31:0] in_cell_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_diffused_value;
  logic [7:0]  out_column;
  logic [7:0]  out_row;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  // shadow copy of the block's state
  tsd_pkg::val_t  trail_shadow [GRID_CELLS];
  bit             cell_written [GRID_CELLS];
  tsd_pkg::gain_t decay_shadow;

  diffused_t  awaited_results[$];
  logic [7:0] centre_cols[$];
  logic [7:0] centre_rows[$];

  int  mismatch_count;
  int  items_sent;
  int  cycle_count;
  bit  calm;

  toroidal_stencil_diffuse #(
    .LOG2_WIDTH  (LOG2_WIDTH),
    .LOG2_HEIGHT (LOG2_HEIGHT)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_cell_value      (in_cell_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_diffused_value (out_diffused_value),
    .out_column         (out_column),
    .out_row            (out_row),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int cell_index(int col, int row);
    return ((row & YMASK) << LOG2_WIDTH) | (col & XMASK);
  endfunction

  // weighted 3x3 sum over the wrapped neighbourhood, /12, then decay with saturation
  function automatic tsd_pkg::val_t predict_diffused(logic [7:0] col, logic [7:0] row);
    tsd_pkg::sum_t acc;
    logic [63:0]   scaled;
    tsd_pkg::val_t nb_val;
    acc = '0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nb_val = trail_shadow[cell_index(int'(col) + dx, int'(row) + dy)];
        acc    = acc + (tsd_pkg::sum_t'(nb_val) << ((dx == 0 && dy == 0) ? 2 : 0));
      end
    end
    scaled = (64'(acc / STENCIL_WEIGHT) * 64'(decay_shadow)) >> tsd_pkg::FRAC_W;
    if (scaled > 64'hFFFF_FFFF) return '1;
    return tsd_pkg::val_t'(scaled);
  endfunction

  function automatic tsd_pkg::val_t pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return tsd_pkg::val_t'($urandom_range(0, 65535));
      3:       return {1'b1, 31'($urandom)};
      default: return tsd_pkg::val_t'($urandom);
    endcase
  endfunction

  // sends one transaction and updates the shadow state when it is accepted
  task automatic send_item(logic cmd, logic [7:0] col, logic [7:0] row, tsd_pkg::val_t value);
    int idx;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_command    = cmd;
    in_column     = col;
    in_row        = row;
    in_cell_value = value;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    idx = cell_index(col, row);
    if (cmd == tsd_pkg::CMD_WRITE) begin
      trail_shadow[idx] = value;
      cell_written[idx] = 1'b1;
    end else begin
      awaited_results.push_back('{predict_diffused(col, row), 8'(col & XMASK),
                                  8'(row & YMASK)});
    end
    items_sent++;
    if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
    @(negedge clk);
  endtask

  // input quiet until every result is back, then let the last write retire
  task automatic drain_results();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_decay(tsd_pkg::gain_t gain);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = gain;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    decay_shadow = gain;
  endtask

  task automatic fill_neighbourhood(logic [7:0] col, logic [7:0] row, tsd_pkg::val_t value);
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        send_item(tsd_pkg::CMD_WRITE, 8'((int'(col) + dx) & XMASK),
                  8'((int'(row) + dy) & YMASK), value);
    centre_cols.push_back(col);
    centre_rows.push_back(row);
  endtask

  // writes any cell of the neighbourhood not yet written, and overwrites a few others
  task automatic prime_neighbourhood(logic [7:0] col, logic [7:0] row);
    logic [7:0] cx;
    logic [7:0] cy;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cx = 8'((int'(col) + dx) & XMASK);
        cy = 8'((int'(row) + dy) & YMASK);
        if (!cell_written[cell_index(cx, cy)] || $urandom_range(0, 3) == 0)
          send_item(tsd_pkg::CMD_WRITE, cx, cy, pick_value());
      end
    end
    centre_cols.push_back(col);
    centre_rows.push_back(row);
  endtask

  task automatic test_edges_at_reset_gain();
    // all-ones around the origin gives the largest average, wrapping on both axes
    fill_neighbourhood(8'd0, 8'd0, '1);
    send_item(tsd_pkg::CMD_QUERY, 8'd0, 8'd0, 32'hDEAD_BEEF);
    fill_neighbourhood(8'd255, 8'd255, '0);
    send_item(tsd_pkg::CMD_QUERY, 8'd255, 8'd255, '1);
    send_item(tsd_pkg::CMD_QUERY, 8'd0, 8'd0, '0);
    send_item(tsd_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h8000_0001);
    send_item(tsd_pkg::CMD_QUERY, 8'd255, 8'd255, 32'h1234_5678);
    send_item(tsd_pkg::CMD_QUERY, 8'd0, 8'd0, '0);
    drain_results();
  endtask

  task automatic test_decay_extremes();
    tsd_pkg::gain_t gains[5];
    gains = '{tsd_pkg::gain_t'(0), tsd_pkg::gain_t'(1), tsd_pkg::gain_t'(65535),
              tsd_pkg::gain_t'(131071), tsd_pkg::GAIN_ONE};
    fill_neighbourhood(8'h55, 8'hAA, '1);
    drain_results();
    foreach (gains[i]) begin
      set_decay(gains[i]);
      send_item(tsd_pkg::CMD_QUERY, 8'h55, 8'hAA, pick_value());
      send_item(tsd_pkg::CMD_QUERY, 8'd0, 8'd0, pick_value());
      send_item(tsd_pkg::CMD_QUERY, 8'd255, 8'd255, pick_value());
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    int         pick;
    int         phase_end;
    logic [7:0] col;
    logic [7:0] row;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       set_decay('0);
        1:       set_decay(tsd_pkg::GAIN_ONE);
        2:       set_decay(tsd_pkg::gain_t'(65535));
        3:       set_decay(tsd_pkg::gain_t'($urandom_range(65537, 131071)));
        default: set_decay(tsd_pkg::gain_t'($urandom_range(0, 65536)));
      endcase
      phase_end = items_sent + $urandom_range(60, 120);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          col = 8'($urandom_range(0, 255));
          row = 8'($urandom_range(0, 255));
          prime_neighbourhood(col, row);
          send_item(tsd_pkg::CMD_QUERY, col, row, pick_value());
        end else if (pick < 85) begin
          // revisit an earlier centre, possibly after its neighbours changed
          pick = $urandom_range(0, centre_cols.size() - 1);
          send_item(tsd_pkg::CMD_QUERY, centre_cols[pick], centre_rows[pick], pick_value());
        end else begin
          send_item(tsd_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), pick_value());
        end
      end
      drain_results();
    end
  endtask

  always @(posedge clk) begin
    diffused_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: column %0d row %0d value %h",
               out_column, out_row, out_diffused_value);
        mismatch_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_diffused_value !== exp_res.value) begin
          $error("diffused_value mismatch: expected %h, got %h", exp_res.value, out_diffused_value);
          mismatch_count++;
        end
        if (out_column !== exp_res.column) begin
          $error("out_column mismatch: expected %0d, got %0d", exp_res.column, out_column);
          mismatch_count++;
        end
        if (out_row !== exp_res.row) begin
          $error("out_row mismatch: expected %0d, got %0d", exp_res.row, out_row);
          mismatch_count++;
        end
      end
    end
  end

  // result side back-pressure in bursts, none once the run turns calm
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (calm) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = tsd_pkg::CMD_WRITE;
    in_column      = '0;
    in_row         = '0;
    in_cell_value  = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    decay_shadow   = tsd_pkg::GAIN_ONE;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edges_at_reset_gain();
    test_decay_extremes();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
